>>> rtl/core/s2c_pkg.sv
// shared types, constants and key tables of the scan code translator
`timescale 1ns / 1ps
package s2c_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int KEY_CODES   = 128;
  localparam int KEY_W       = $clog2(KEY_CODES);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RES     = 3;
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RES);
  localparam int NUM_CAND    = 5;
  localparam int CAND_CNT_W  = $clog2(NUM_CAND + 1);

  localparam logic [7:0] LED_CMD     = 8'hED;
  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] RESEND_BYTE = 8'hFE;
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  localparam logic [KEY_W-1:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_RSHIFT  = 7'h36;
  localparam logic [KEY_W-1:0] KEY_CONTROL = 7'h1D;
  localparam logic [KEY_W-1:0] KEY_CAPS    = 7'h3A;
  localparam logic [KEY_W-1:0] KEY_NUM     = 7'h45;
  localparam logic [KEY_W-1:0] KEY_SCROLL  = 7'h46;
  localparam logic [KEY_W-1:0] KEY_C       = 7'h2E;
  localparam logic [KEY_W-1:0] KEY_TAB     = 7'h0F;
  localparam logic [KEY_W-1:0] KEY_F1      = 7'h3B;
  localparam logic [KEY_W-1:0] KEY_F2      = 7'h3C;
  localparam logic [KEY_W-1:0] KEY_F11     = 7'h57;

  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  localparam logic [7:0] EV_TAB    = 8'd0;
  localparam logic [7:0] EV_BREAK  = 8'd1;
  localparam logic [7:0] EV_NEWCON = 8'd2;
  localparam logic [7:0] EV_RAISE  = 8'd3;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_PORT  = 2'd1,
    KIND_EVENT = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_LOCK_LEDS = 1'b0,
    CFG_TARGET    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       we;
    cfg_idx_t   index;
    logic [2:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] value;
  } opt_res_t;

  // key decoder to command queue
  typedef struct packed {
    logic       valid;
    logic       push_led;
    logic [2:0] leds;
    logic       ack;
    logic       resend;
  } qstep_t;

  typedef struct packed {
    opt_res_t chr;
    opt_res_t evt;
  } key_res_t;

  typedef struct packed {
    opt_res_t send1;
    opt_res_t resend;
    opt_res_t send2;
  } q_res_t;

  function automatic logic [7:0] plain_char(input logic [KEY_W-1:0] key);
    logic [7:0] c;
    unique case (key)
      7'h02: c = 8'h31;  7'h03: c = 8'h32;  7'h04: c = 8'h33;  7'h05: c = 8'h34;
      7'h06: c = 8'h35;  7'h07: c = 8'h36;  7'h08: c = 8'h37;  7'h09: c = 8'h38;
      7'h0A: c = 8'h39;  7'h0B: c = 8'h30;  7'h0C: c = 8'h2D;  7'h0D: c = 8'h5E;
      7'h0E: c = 8'h08;
      7'h10: c = 8'h51;  7'h11: c = 8'h57;  7'h12: c = 8'h45;  7'h13: c = 8'h52;
      7'h14: c = 8'h54;  7'h15: c = 8'h59;  7'h16: c = 8'h55;  7'h17: c = 8'h49;
      7'h18: c = 8'h4F;  7'h19: c = 8'h50;  7'h1A: c = 8'h40;  7'h1B: c = 8'h5B;
      7'h1C: c = 8'h0A;  7'h1E: c = 8'h41;  7'h1F: c = 8'h53;
      7'h20: c = 8'h44;  7'h21: c = 8'h46;  7'h22: c = 8'h47;  7'h23: c = 8'h48;
      7'h24: c = 8'h4A;  7'h25: c = 8'h4B;  7'h26: c = 8'h4C;  7'h27: c = 8'h3B;
      7'h28: c = 8'h3A;  7'h2B: c = 8'h5D;  7'h2C: c = 8'h5A;  7'h2D: c = 8'h58;
      7'h2E: c = 8'h43;  7'h2F: c = 8'h56;
      7'h30: c = 8'h42;  7'h31: c = 8'h4E;  7'h32: c = 8'h4D;  7'h33: c = 8'h2C;
      7'h34: c = 8'h2E;  7'h35: c = 8'h2F;  7'h37: c = 8'h2A;  7'h39: c = 8'h20;
      7'h47: c = 8'h37;  7'h48: c = 8'h38;  7'h49: c = 8'h39;  7'h4A: c = 8'h2D;
      7'h4B: c = 8'h34;  7'h4C: c = 8'h35;  7'h4D: c = 8'h36;  7'h4E: c = 8'h2B;
      7'h4F: c = 8'h31;  7'h50: c = 8'h32;  7'h51: c = 8'h33;  7'h52: c = 8'h30;
      7'h53: c = 8'h2E;
      7'h73: c = 8'h5C;  7'h7D: c = 8'h5C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // shifted table differs from the plain one only on these keys
  function automatic logic [7:0] shift_char(input logic [KEY_W-1:0] key);
    logic [7:0] c;
    unique case (key)
      7'h02: c = 8'h21;  7'h03: c = 8'h22;  7'h04: c = 8'h23;  7'h05: c = 8'h24;
      7'h06: c = 8'h25;  7'h07: c = 8'h26;  7'h08: c = 8'h27;  7'h09: c = 8'h28;
      7'h0A: c = 8'h29;  7'h0B: c = 8'h7E;  7'h0C: c = 8'h3D;  7'h0D: c = 8'h7E;
      7'h1A: c = 8'h60;  7'h1B: c = 8'h7B;  7'h27: c = 8'h2B;  7'h28: c = 8'h2A;
      7'h2B: c = 8'h7D;  7'h33: c = 8'h3C;  7'h34: c = 8'h3E;  7'h35: c = 8'h3F;
      7'h73: c = 8'h5F;  7'h7D: c = 8'h7C;
      default: c = plain_char(key);
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/s2c_key_decode.sv
// key state, character translation and window events
`timescale 1ns / 1ps
module s2c_key_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        scan_code,
  input  s2c_pkg::cfg_wr_t  cfg,
  output s2c_pkg::key_res_t kres,
  output s2c_pkg::qstep_t   qstep
);
  import s2c_pkg::*;

  logic [1:0]           shift_bits, shift_bits_next;
  logic                 ctrl_down, ctrl_down_next;
  logic [2:0]           lock_leds, lock_leds_next;
  logic                 target_present, target_present_next;
  logic [KEY_CODES-1:0] pressed_map;

  logic             make, first_make, brk, sh_any;
  logic [KEY_W-1:0] key;
  logic [7:0]       ch;
  logic [2:0]       led_bit;

  always_comb begin
    make       = ~scan_code[7];
    key        = scan_code[KEY_W-1:0];
    first_make = step & make & ~pressed_map[key];
    brk        = step & scan_code[7];
    sh_any     = |shift_bits;

    ch = sh_any ? shift_char(key) : plain_char(key);
    // caps lock and shift cancel each other for letters
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z && (lock_leds[2] == sh_any)) begin
      ch = ch | CASE_BIT;
    end

    shift_bits_next     = shift_bits;
    ctrl_down_next      = ctrl_down;
    lock_leds_next      = lock_leds;
    target_present_next = target_present;

    kres.chr.valid = first_make & (ch != 8'h00) & target_present
                     & ~(ctrl_down & (key == KEY_C));
    kres.chr.kind  = KIND_CHAR;
    kres.chr.value = ch;
    kres.evt.valid = 1'b0;
    kres.evt.kind  = KIND_EVENT;
    kres.evt.value = EV_TAB;

    led_bit = 3'b000;
    if (key == KEY_CAPS)   led_bit = LED_CAPS;
    if (key == KEY_NUM)    led_bit = LED_NUM;
    if (key == KEY_SCROLL) led_bit = LED_SCROLL;

    if (first_make) begin
      if (key == KEY_LSHIFT)  shift_bits_next[0] = 1'b1;
      if (key == KEY_RSHIFT)  shift_bits_next[1] = 1'b1;
      if (key == KEY_CONTROL) ctrl_down_next = 1'b1;
      lock_leds_next = lock_leds ^ led_bit;

      if (key == KEY_TAB && target_present) begin
        kres.evt.valid = 1'b1;
        kres.evt.value = EV_TAB;
      end else if (key == KEY_F1 && (|shift_bits_next) && target_present) begin
        kres.evt.valid = 1'b1;
        kres.evt.value = EV_BREAK;
      end else if ((key == KEY_F2 && (|shift_bits_next)) || (key == KEY_C && ctrl_down)) begin
        kres.evt.valid      = 1'b1;
        kres.evt.value      = EV_NEWCON;
        target_present_next = 1'b1;
      end else if (key == KEY_F11) begin
        kres.evt.valid = 1'b1;
        kres.evt.value = EV_RAISE;
      end
    end

    if (brk) begin
      if (key == KEY_LSHIFT)  shift_bits_next[0] = 1'b0;
      if (key == KEY_RSHIFT)  shift_bits_next[1] = 1'b0;
      if (key == KEY_CONTROL) ctrl_down_next = 1'b0;
    end

    qstep.valid    = step;
    qstep.push_led = first_make & (led_bit != 3'b000);
    qstep.leds     = lock_leds_next;
    qstep.ack      = brk & (scan_code == ACK_BYTE);
    qstep.resend   = brk & (scan_code == RESEND_BYTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits     <= '0;
      ctrl_down      <= 1'b0;
      lock_leds      <= '0;
      target_present <= 1'b1;
      pressed_map    <= '0;
    end else begin
      shift_bits     <= shift_bits_next;
      ctrl_down      <= ctrl_down_next;
      lock_leds      <= lock_leds_next;
      target_present <= target_present_next;
      if (first_make) begin
        pressed_map[key] <= 1'b1;
      end else if (brk) begin
        pressed_map[key] <= 1'b0;
      end
      if (cfg.we) begin
        unique case (cfg.index)
          CFG_LOCK_LEDS: lock_leds      <= cfg.data;
          CFG_TARGET:    target_present <= cfg.data[0];
          default:       ;
        endcase
      end
    end
  end

endmodule

>>> rtl/core/s2c_cmd_queue.sv
// keyboard command queue with ack wait and resend
`timescale 1ns / 1ps
module s2c_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  s2c_pkg::qstep_t  qstep,
  input  s2c_pkg::cfg_wr_t cfg,
  output s2c_pkg::q_res_t  qres
);
  import s2c_pkg::*;

  localparam logic [QCNT_W:0] DEPTH_X = (QCNT_W + 1)'(QUEUE_DEPTH);

  // head always sits at entry 0, pops shift the line down
  logic [7:0]        q [QUEUE_DEPTH];
  logic [7:0]        q_ext [QUEUE_DEPTH + 2];
  logic [7:0]        q_next [QUEUE_DEPTH];
  logic [QCNT_W-1:0] count, count_next;
  logic              awaiting_ack, awaiting_ack_next;
  logic [7:0]        byte_in_flight, byte_in_flight_next;

  logic              send1, send2, push_ed, push_lv, a1, a2, restart;
  logic [QCNT_W:0]   c0, c1, c2, c3, pos;
  logic [1:0]        pop;
  logic [7:0]        b2, bif1, shifted;

  always_comb begin
    restart = cfg.we & (cfg.index == CFG_LOCK_LEDS);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_ext[i] = q[i];
    end
    q_ext[QUEUE_DEPTH]     = 8'h00;
    q_ext[QUEUE_DEPTH + 1] = 8'h00;

    c0    = {1'b0, count};
    send1 = qstep.valid & (c0 != '0) & ~awaiting_ack;
    c1    = c0 - {{QCNT_W{1'b0}}, send1};
    a1    = awaiting_ack | send1;
    bif1  = send1 ? q[0] : byte_in_flight;

    push_ed = qstep.push_led & (c1 < DEPTH_X);
    push_lv = qstep.push_led & ((c1 + {{QCNT_W{1'b0}}, push_ed}) < DEPTH_X);
    c2      = c1 + {{QCNT_W{1'b0}}, push_ed} + {{QCNT_W{1'b0}}, push_lv};
    a2      = qstep.ack ? 1'b0 : a1;

    send2 = qstep.valid & (c2 != '0) & ~a2;
    // next head byte: old entry if one is left, else the command just pushed
    if (send1) begin
      b2 = (c0 > (QCNT_W + 1)'(1)) ? q[1] : LED_CMD;
    end else begin
      b2 = (c0 != '0) ? q[0] : LED_CMD;
    end
    c3  = c2 - {{QCNT_W{1'b0}}, send2};
    pop = {1'b0, send1} + {1'b0, send2};

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      shifted = q_ext[i];
      if (pop == 2'd1) shifted = q_ext[i + 1];
      if (pop == 2'd2) shifted = q_ext[i + 2];
      pos = (QCNT_W + 1)'(i) + {{(QCNT_W - 1){1'b0}}, pop};
      if (pos < c0) begin
        q_next[i] = shifted;
      end else if (pos == c0) begin
        q_next[i] = LED_CMD;
      end else begin
        q_next[i] = {5'b0, qstep.leds};
      end
    end

    count_next          = c3[QCNT_W-1:0];
    awaiting_ack_next   = a2 | send2;
    byte_in_flight_next = send2 ? b2 : bif1;

    qres.send1.valid  = send1;
    qres.send1.kind   = KIND_PORT;
    qres.send1.value  = q[0];
    qres.resend.valid = qstep.valid & qstep.resend & a1;
    qres.resend.kind  = KIND_PORT;
    qres.resend.value = bif1;
    qres.send2.valid  = send2;
    qres.send2.kind   = KIND_PORT;
    qres.send2.value  = b2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= QCNT_W'(2);
      awaiting_ack   <= 1'b0;
      byte_in_flight <= 8'h00;
      q[0]           <= LED_CMD;
      q[1]           <= 8'h00;
    end else if (restart) begin
      count          <= QCNT_W'(2);
      awaiting_ack   <= 1'b0;
      byte_in_flight <= 8'h00;
      q[0]           <= LED_CMD;
      q[1]           <= {5'b0, cfg.data};
    end else if (qstep.valid) begin
      count          <= count_next;
      awaiting_ack   <= awaiting_ack_next;
      byte_in_flight <= byte_in_flight_next;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        q[i] <= q_next[i];
      end
    end
  end

endmodule

>>> rtl/core/s2c_result_buf.sv
// result packing and two-slot output buffer
`timescale 1ns / 1ps
module s2c_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  s2c_pkg::opt_res_t cand [s2c_pkg::NUM_CAND],
  output logic              in_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);
  import s2c_pkg::*;

  opt_res_t             packed_res [MAX_RES];
  logic [CAND_CNT_W-1:0] n;
  logic [RES_CNT_W-1:0]  packed_cnt;

  logic                 pend_valid;
  logic [RES_CNT_W-1:0] pend_cnt;
  opt_res_t             pend_res [MAX_RES];
  logic [RES_CNT_W-1:0] drain_cnt, drain_idx;
  opt_res_t             drain_res [MAX_RES];
  logic                 drain_busy, move;

  // squeeze the candidate results of one word into order
  always_comb begin
    n = '0;
    for (int s = 0; s < MAX_RES; s++) begin
      packed_res[s] = cand[0];
    end
    for (int c = 0; c < NUM_CAND; c++) begin
      if (cand[c].valid) begin
        for (int s = 0; s < MAX_RES; s++) begin
          if (n == CAND_CNT_W'(s)) packed_res[s] = cand[c];
        end
        n = n + CAND_CNT_W'(1);
      end
    end
    packed_cnt = (n > CAND_CNT_W'(MAX_RES)) ? RES_CNT_W'(MAX_RES) : n[RES_CNT_W-1:0];
  end

  always_comb begin
    drain_busy = drain_idx != drain_cnt;
    move       = pend_valid & ~drain_busy;
    in_ready   = ~pend_valid | ~drain_busy;
    m_tvalid   = drain_busy;
    m_tdata    = drain_res[drain_idx[RES_IDX_W-1:0]].value;
    m_tuser    = drain_res[drain_idx[RES_IDX_W-1:0]].kind;
    m_tlast    = (drain_idx + RES_CNT_W'(1)) == drain_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      drain_cnt  <= '0;
      drain_idx  <= '0;
    end else begin
      if (move) begin
        drain_cnt <= pend_cnt;
        drain_idx <= '0;
      end else if (m_tvalid && m_tready) begin
        drain_idx <= drain_idx + RES_CNT_W'(1);
      end
      if (load && packed_cnt != '0) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_cnt <= packed_cnt;
      pend_res <= packed_res;
    end
    if (move) begin
      drain_res <= pend_res;
    end
  end

endmodule

>>> rtl/core/scancode_to_char_translator.sv
// top level of the set-1 scan code to character translator
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] scan code
// m_*       out  m_tvalid/m_tready  m_tdata value, m_tuser kind, m_tlast
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// a word is decoded and all key and queue state updated in the cycle it is taken;
// its zero to three results are packed into a pending slot and then drained,
// one result per cycle while the sink is ready, from an output slot
// with a free-running sink a word with no result is taken every cycle, and a new
// word can be taken while the results of the one before are still drained
// reset leaves the led command and led bits queued for the keyboard
// a stalled sink holds the output slot while one more word is taken
`timescale 1ns / 1ps
module scancode_to_char_translator (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] scan_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_value
  output logic [1:0] m_tuser,   // [1:0] out_kind
  output logic       m_tlast,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);
  import s2c_pkg::*;

  logic     step;
  cfg_wr_t  cfg;
  key_res_t kres;
  qstep_t   qstep;
  q_res_t   qres;
  opt_res_t cand [NUM_CAND];

  always_comb begin
    step      = s_tvalid & s_tready;
    cfg.we    = cfg_we;
    cfg.index = cfg_idx_t'(cfg_index);
    cfg.data  = cfg_data;
    // port send, then the character and event results, then resend, then the follow-up send
    cand[0] = qres.send1;
    cand[1] = kres.chr;
    cand[2] = kres.evt;
    cand[3] = qres.resend;
    cand[4] = qres.send2;
  end

  s2c_key_decode u_key (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .scan_code (s_tdata),
    .cfg       (cfg),
    .kres      (kres),
    .qstep     (qstep)
  );

  s2c_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qstep (qstep),
    .cfg   (cfg),
    .qres  (qres)
  );

  s2c_result_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .cand     (cand),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
